FILE: src/tcpoq_pkg.sv
package tcpoq_pkg;

    localparam int HIGH_DEPTH = 4;
    localparam int LOW_DEPTH  = 8;

    localparam int HI_CNT_W = $clog2(HIGH_DEPTH + 1);
    localparam int LO_CNT_W = $clog2(LOW_DEPTH + 1);
    localparam int CNT_W    = (HI_CNT_W > LO_CNT_W) ? HI_CNT_W : LO_CNT_W;
    localparam int HI_PTR_W = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
    localparam int LO_PTR_W = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
    localparam int PTR_W    = (HI_PTR_W > LO_PTR_W) ? HI_PTR_W : LO_PTR_W;

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int ID_W       = 16;
    localparam int ITEM_W     = 8;
    localparam int QTY_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ID_W-1:0]   FIRST_ID_RESET   = 16'd100;
    localparam logic [ITEM_W-1:0] ITEM_COUNT_RESET = 8'd18;

    typedef enum logic [KIND_W-1:0] {
        KIND_PLACE  = 2'd0,
        KIND_SERVE  = 2'd1,
        KIND_CANCEL = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_INVALID   = 3'd2,
        ST_SERVED    = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CANCELLED = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_ORDER_ID = 2'd0,
        REG_ITEM_COUNT     = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ITEM_W-1:0] item;
        logic [QTY_W-1:0]  qty;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SERVE_POP,
        S_SCAN_CHK,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic exec_place;
        logic exec_invalid;
        logic serve_rd;
        logic serve_pop;
        logic serve_empty;
        logic scan_start_high;
        logic scan_start_low;
        logic scan_next;
        logic shift_rd;
        logic shift_wr;
        logic cancel_done;
        logic not_found;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t kind;
        logic  any_nz;
        logic  sel_high;
        logic  scan_end;
        logic  shift_end;
        logic  match;
        logic  out_busy;
    } stat_t;

endpackage

FILE: src/tcpoq_if.sv
interface tcpoq_req_if import tcpoq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic              is_high_class;
    logic [ITEM_W-1:0] item_number;
    logic [QTY_W-1:0]  quantity;
    logic [ID_W-1:0]   cancel_id;

    modport source (output valid, kind, is_high_class, item_number, quantity, cancel_id,
                    input ready);
    modport sink (input valid, kind, is_high_class, item_number, quantity, cancel_id,
                  output ready);
endinterface

interface tcpoq_rsp_if import tcpoq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     order_id;
    logic                from_high_class;
    logic [ITEM_W-1:0]   served_item;
    logic [QTY_W-1:0]    served_quantity;

    modport source (output valid, status, order_id, from_high_class, served_item,
                    served_quantity, input ready);
    modport sink (input valid, status, order_id, from_high_class, served_item,
                  served_quantity, output ready);
endinterface

interface tcpoq_cfg_if import tcpoq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tcpoq_ctrl.sv
module tcpoq_ctrl import tcpoq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.kind)
                    KIND_SERVE:  state_next = stat.any_nz ? S_SERVE_POP : S_FINISH;
                    KIND_CANCEL: state_next = S_SCAN_CHK;
                    default:     state_next = S_FINISH;
                endcase
            end
            S_SERVE_POP: state_next = S_FINISH;
            S_SCAN_CHK:
            begin
                if (!stat.scan_end)
                begin
                    state_next = S_SCAN_CMP;
                end
                else if (!stat.sel_high)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_CMP:  state_next = stat.match ? S_SHIFT_CHK : S_SCAN_CHK;
            S_SHIFT_CHK: state_next = stat.shift_end ? S_FINISH : S_SHIFT_WR;
            S_SHIFT_WR:  state_next = S_SHIFT_CHK;
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE: cmd.in_ready = 1'b1;
            S_EXEC:
            begin
                unique case (stat.kind)
                    KIND_PLACE:  cmd.exec_place = 1'b1;
                    KIND_SERVE:
                    begin
                        cmd.serve_rd    = stat.any_nz;
                        cmd.serve_empty = !stat.any_nz;
                    end
                    KIND_CANCEL: cmd.scan_start_high = 1'b1;
                    default:     cmd.exec_invalid = 1'b1;
                endcase
            end
            S_SERVE_POP: cmd.serve_pop = 1'b1;
            S_SCAN_CHK:
            begin
                cmd.scan_start_low = stat.scan_end && stat.sel_high;
                cmd.not_found      = stat.scan_end && !stat.sel_high;
            end
            S_SCAN_CMP:  cmd.scan_next = !stat.match;
            S_SHIFT_CHK:
            begin
                cmd.cancel_done = stat.shift_end;
                cmd.shift_rd    = !stat.shift_end;
            end
            S_SHIFT_WR:  cmd.shift_wr = 1'b1;
            S_FINISH:    cmd.out_load = !stat.out_busy;
            default:     cmd = '0;
        endcase
    end

endmodule

FILE: src/tcpoq_dp.sv
module tcpoq_dp import tcpoq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    tcpoq_req_if.sink  req,
    tcpoq_rsp_if.source rsp,
    tcpoq_cfg_if.sink  cfg,
    input  cmd_t       cmd,
    output stat_t      stat
);

    function automatic logic [HI_PTR_W-1:0] hi_inc(input logic [HI_PTR_W-1:0] p);
        return (p == HI_PTR_W'(HIGH_DEPTH - 1)) ? '0 : HI_PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [HI_PTR_W-1:0] hi_dec(input logic [HI_PTR_W-1:0] p);
        return (p == '0) ? HI_PTR_W'(HIGH_DEPTH - 1) : HI_PTR_W'(p - 1'b1);
    endfunction

    function automatic logic [LO_PTR_W-1:0] lo_inc(input logic [LO_PTR_W-1:0] p);
        return (p == LO_PTR_W'(LOW_DEPTH - 1)) ? '0 : LO_PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [LO_PTR_W-1:0] lo_dec(input logic [LO_PTR_W-1:0] p);
        return (p == '0) ? LO_PTR_W'(LOW_DEPTH - 1) : LO_PTR_W'(p - 1'b1);
    endfunction

    logic [KIND_W-1:0] kind_reg;
    logic              cls_reg;
    logic [ITEM_W-1:0] item_reg;
    logic [QTY_W-1:0]  qty_reg;
    logic [ID_W-1:0]   cid_reg;

    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [ITEM_W-1:0] item_count_reg, item_count_next;

    logic [HI_PTR_W-1:0] hi_head_reg, hi_head_next, hi_tail_reg, hi_tail_next;
    logic [HI_CNT_W-1:0] hi_count_reg, hi_count_next;
    logic [LO_PTR_W-1:0] lo_head_reg, lo_head_next, lo_tail_reg, lo_tail_next;
    logic [LO_CNT_W-1:0] lo_count_reg, lo_count_next;

    logic             sel_high_reg, sel_high_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] k_reg, k_next;

    entry_t hi_mem [HIGH_DEPTH];
    entry_t lo_mem [LOW_DEPTH];
    entry_t hi_rdata_reg, lo_rdata_reg;

    status_t           wk_status_reg, wk_status_next;
    logic [ID_W-1:0]   wk_oid_reg, wk_oid_next;
    logic              wk_cls_reg, wk_cls_next;
    logic [ITEM_W-1:0] wk_item_reg, wk_item_next;
    logic [QTY_W-1:0]  wk_qty_reg, wk_qty_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_oid_reg;
    logic              out_cls_reg;
    logic [ITEM_W-1:0] out_item_reg;
    logic [QTY_W-1:0]  out_qty_reg;

    logic                load;
    logic [HI_PTR_W-1:0] hi_ptr;
    logic [LO_PTR_W-1:0] lo_ptr;
    logic [PTR_W-1:0]    ptr_inc;
    entry_t              rdata_sel;
    entry_t              new_entry;
    logic [CNT_W-1:0]    count_sel;
    logic                place_ok;
    logic                hi_full;
    logic                lo_full;
    logic                place_full;
    logic                push_hi;
    logic                push_lo;
    logic                hi_we;
    logic                lo_we;
    logic [HI_PTR_W-1:0] hi_waddr, hi_raddr;
    logic [LO_PTR_W-1:0] lo_waddr, lo_raddr;
    entry_t              hi_wdata, lo_wdata;

    assign load      = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;

    assign hi_ptr    = ptr_reg[HI_PTR_W-1:0];
    assign lo_ptr    = ptr_reg[LO_PTR_W-1:0];
    assign ptr_inc   = sel_high_reg ? PTR_W'(hi_inc(hi_ptr)) : PTR_W'(lo_inc(lo_ptr));
    assign rdata_sel = sel_high_reg ? hi_rdata_reg : lo_rdata_reg;
    assign count_sel = sel_high_reg ? CNT_W'(hi_count_reg) : CNT_W'(lo_count_reg);

    assign place_ok   = (item_reg != '0) && (item_reg <= item_count_reg) && (qty_reg != '0);
    assign hi_full    = hi_count_reg == HI_CNT_W'(HIGH_DEPTH);
    assign lo_full    = lo_count_reg == LO_CNT_W'(LOW_DEPTH);
    assign place_full = cls_reg ? hi_full : lo_full;
    assign push_hi    = cmd.exec_place && place_ok && cls_reg && !hi_full;
    assign push_lo    = cmd.exec_place && place_ok && !cls_reg && !lo_full;
    assign new_entry  = '{id: next_id_reg, item: item_reg, qty: qty_reg};

    assign hi_raddr = cmd.serve_rd ? hi_head_reg : (cmd.shift_rd ? hi_inc(hi_ptr) : hi_ptr);
    assign lo_raddr = cmd.serve_rd ? lo_head_reg : (cmd.shift_rd ? lo_inc(lo_ptr) : lo_ptr);

    assign hi_we    = push_hi || (cmd.shift_wr && sel_high_reg);
    assign lo_we    = push_lo || (cmd.shift_wr && !sel_high_reg);
    assign hi_waddr = cmd.shift_wr ? hi_ptr : hi_tail_reg;
    assign lo_waddr = cmd.shift_wr ? lo_ptr : lo_tail_reg;
    assign hi_wdata = cmd.shift_wr ? rdata_sel : new_entry;
    assign lo_wdata = cmd.shift_wr ? rdata_sel : new_entry;

    always_ff @(posedge clk)
    begin
        if (hi_we)
        begin
            hi_mem[hi_waddr] <= hi_wdata;
        end
        hi_rdata_reg <= hi_mem[hi_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
        begin
            lo_mem[lo_waddr] <= lo_wdata;
        end
        lo_rdata_reg <= lo_mem[lo_raddr];
    end

    always_comb
    begin
        next_id_next    = next_id_reg;
        item_count_next = item_count_reg;
        if (cfg.valid && (cfg.index == REG_FIRST_ORDER_ID))
        begin
            next_id_next = cfg.data[ID_W-1:0];
        end
        else if (cmd.exec_place && place_ok)
        begin
            next_id_next = ID_W'(next_id_reg + 1'b1);
        end
        if (cfg.valid && (cfg.index == REG_ITEM_COUNT))
        begin
            item_count_next = cfg.data[ITEM_W-1:0];
        end
    end

    always_comb
    begin
        hi_head_next  = hi_head_reg;
        hi_tail_next  = hi_tail_reg;
        hi_count_next = hi_count_reg;
        lo_head_next  = lo_head_reg;
        lo_tail_next  = lo_tail_reg;
        lo_count_next = lo_count_reg;
        if (push_hi)
        begin
            hi_tail_next  = hi_inc(hi_tail_reg);
            hi_count_next = HI_CNT_W'(hi_count_reg + 1'b1);
        end
        if (push_lo)
        begin
            lo_tail_next  = lo_inc(lo_tail_reg);
            lo_count_next = LO_CNT_W'(lo_count_reg + 1'b1);
        end
        if (cmd.serve_pop && sel_high_reg)
        begin
            hi_head_next  = hi_inc(hi_head_reg);
            hi_count_next = HI_CNT_W'(hi_count_reg - 1'b1);
        end
        if (cmd.serve_pop && !sel_high_reg)
        begin
            lo_head_next  = lo_inc(lo_head_reg);
            lo_count_next = LO_CNT_W'(lo_count_reg - 1'b1);
        end
        if (cmd.cancel_done && sel_high_reg)
        begin
            hi_tail_next  = hi_dec(hi_tail_reg);
            hi_count_next = HI_CNT_W'(hi_count_reg - 1'b1);
        end
        if (cmd.cancel_done && !sel_high_reg)
        begin
            lo_tail_next  = lo_dec(lo_tail_reg);
            lo_count_next = LO_CNT_W'(lo_count_reg - 1'b1);
        end
    end

    always_comb
    begin
        sel_high_next = sel_high_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        if (cmd.serve_rd)
        begin
            sel_high_next = hi_count_reg != '0;
        end
        if (cmd.scan_start_high)
        begin
            sel_high_next = 1'b1;
            ptr_next      = PTR_W'(hi_head_reg);
            k_next        = '0;
        end
        if (cmd.scan_start_low)
        begin
            sel_high_next = 1'b0;
            ptr_next      = PTR_W'(lo_head_reg);
            k_next        = '0;
        end
        if (cmd.scan_next || cmd.shift_wr)
        begin
            ptr_next = ptr_inc;
            k_next   = CNT_W'(k_reg + 1'b1);
        end
    end

    always_comb
    begin
        wk_status_next = wk_status_reg;
        wk_oid_next    = wk_oid_reg;
        wk_cls_next    = wk_cls_reg;
        wk_item_next   = wk_item_reg;
        wk_qty_next    = wk_qty_reg;
        if (cmd.exec_place || cmd.exec_invalid || cmd.serve_empty || cmd.not_found ||
            cmd.cancel_done || cmd.serve_pop)
        begin
            wk_status_next = ST_INVALID;
            wk_oid_next    = '0;
            wk_cls_next    = 1'b0;
            wk_item_next   = '0;
            wk_qty_next    = '0;
        end
        if (cmd.exec_place && place_ok)
        begin
            wk_status_next = place_full ? ST_FULL : ST_PLACED;
            wk_oid_next    = next_id_reg;
            wk_cls_next    = cls_reg;
        end
        if (cmd.serve_empty)
        begin
            wk_status_next = ST_EMPTY;
        end
        if (cmd.serve_pop)
        begin
            wk_status_next = ST_SERVED;
            wk_oid_next    = rdata_sel.id;
            wk_cls_next    = sel_high_reg;
            wk_item_next   = rdata_sel.item;
            wk_qty_next    = rdata_sel.qty;
        end
        if (cmd.cancel_done)
        begin
            wk_status_next = ST_CANCELLED;
            wk_oid_next    = cid_reg;
            wk_cls_next    = sel_high_reg;
        end
        if (cmd.not_found)
        begin
            wk_status_next = ST_NOT_FOUND;
            wk_oid_next    = cid_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg    <= FIRST_ID_RESET;
            item_count_reg <= ITEM_COUNT_RESET;
            hi_head_reg    <= '0;
            hi_tail_reg    <= '0;
            hi_count_reg   <= '0;
            lo_head_reg    <= '0;
            lo_tail_reg    <= '0;
            lo_count_reg   <= '0;
            sel_high_reg   <= 1'b0;
            ptr_reg        <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            next_id_reg    <= next_id_next;
            item_count_reg <= item_count_next;
            hi_head_reg    <= hi_head_next;
            hi_tail_reg    <= hi_tail_next;
            hi_count_reg   <= hi_count_next;
            lo_head_reg    <= lo_head_next;
            lo_tail_reg    <= lo_tail_next;
            lo_count_reg   <= lo_count_next;
            sel_high_reg   <= sel_high_next;
            ptr_reg        <= ptr_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= req.kind;
            cls_reg  <= req.is_high_class;
            item_reg <= req.item_number;
            qty_reg  <= req.quantity;
            cid_reg  <= req.cancel_id;
        end
        wk_status_reg <= wk_status_next;
        wk_oid_reg    <= wk_oid_next;
        wk_cls_reg    <= wk_cls_next;
        wk_item_reg   <= wk_item_next;
        wk_qty_reg    <= wk_qty_next;
        if (cmd.out_load)
        begin
            out_status_reg <= wk_status_reg;
            out_oid_reg    <= wk_oid_reg;
            out_cls_reg    <= wk_cls_reg;
            out_item_reg   <= wk_item_reg;
            out_qty_reg    <= wk_qty_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.order_id        = out_oid_reg;
    assign rsp.from_high_class = out_cls_reg;
    assign rsp.served_item     = out_item_reg;
    assign rsp.served_quantity = out_qty_reg;

    assign stat.in_valid  = req.valid;
    assign stat.kind      = kind_t'(kind_reg);
    assign stat.any_nz    = (hi_count_reg != '0) || (lo_count_reg != '0);
    assign stat.sel_high  = sel_high_reg;
    assign stat.scan_end  = k_reg == count_sel;
    assign stat.shift_end = CNT_W'(k_reg + 1'b1) == count_sel;
    assign stat.match     = rdata_sel.id == cid_reg;
    assign stat.out_busy  = out_valid_reg && !rsp.ready;

endmodule

FILE: src/two_class_priority_order_queue.sv
// Two-class order queue: place, serve (high class first) and cancel-by-id requests enter
// on req, one result per request leaves on rsp, and cfg writes the first order id (index 0,
// also reloads the id counter) and the largest valid item number (index 1). One request is
// worked at a time; a finished result waits in the rsp output register while the next
// request is taken. Cancel walks the stored entries one at a time through the registered read
// port of each queue memory: it scans the high queue first, then the low queue if the high
// queue misses, and then moves each later entry of that queue down to close the gap. The
// user must see that configuration is written only while no request is in flight; the
// block itself does not enforce this.
module two_class_priority_order_queue import tcpoq_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    tcpoq_req_if.sink   req,
    tcpoq_rsp_if.source rsp,
    tcpoq_cfg_if.sink   cfg
);

    cmd_t  cmd;
    stat_t stat;

    tcpoq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    tcpoq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

FILE: src/tcpoq_checker.sv
module tcpoq_checker import tcpoq_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ID_W-1:0]     order_id,
    input logic [ITEM_W-1:0]   served_item,
    input logic [QTY_W-1:0]    served_quantity
);

    logic [1:0] outstanding_reg, outstanding_next;

    assign outstanding_next = 2'(outstanding_reg + (req_valid && req_ready)
                                 - (rsp_valid && rsp_ready));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("result without an accepted item");

    a_one_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 |-> !req_ready)
        else $error("item taken while one is in work and one waits");

    a_served_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_SERVED) |-> (served_item != '0 && served_quantity != '0))
        else $error("served entry with zero item or quantity");

    a_other_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_SERVED) |-> (served_item == '0 && served_quantity == '0))
        else $error("item fields set on a result that is not served");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(order_id)))
        else $error("stalled result changed");

endmodule

bind two_class_priority_order_queue tcpoq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .order_id        (rsp.order_id),
    .served_item     (rsp.served_item),
    .served_quantity (rsp.served_quantity)
);

FILE: test/two_class_priority_order_queue_tb.sv
import tcpoq_pkg::*;

typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              is_high;
    logic [ITEM_W-1:0] item;
    logic [QTY_W-1:0]  qty;
    logic [ID_W-1:0]   cancel_id;
} order_request_t;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     order_id;
    logic                from_high;
    logic [ITEM_W-1:0]   item;
    logic [QTY_W-1:0]    qty;
} order_result_t;

class order_queue_mirror;
    entry_t            high_q[$];
    entry_t            low_q[$];
    logic [ID_W-1:0]   next_id;
    logic [ITEM_W-1:0] max_item;
    order_result_t     awaited_results[$];
    int                errors;

    function new();
        next_id  = FIRST_ID_RESET;
        max_item = ITEM_COUNT_RESET;
        errors   = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        if (index == REG_FIRST_ORDER_ID)
            next_id = data[ID_W-1:0];
        else if (index == REG_ITEM_COUNT)
            max_item = data[ITEM_W-1:0];
    endfunction

    function int find_id(entry_t q[$], logic [ID_W-1:0] id);
        foreach (q[k])
            if (q[k].id == id)
                return k;
        return -1;
    endfunction

    function logic [ID_W-1:0] pick_live_id();
        int k;
        k = $urandom_range(high_q.size() + low_q.size());
        if (k < high_q.size())
            return high_q[k].id;
        if (k < high_q.size() + low_q.size())
            return low_q[k - high_q.size()].id;
        return next_id;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function void note_request(order_request_t r);
        order_result_t res;
        entry_t        e;
        int            pos;
        res        = '0;
        res.status = ST_INVALID;
        case (r.kind)
            KIND_PLACE:
                if (r.item != 0 && r.item <= max_item && r.qty != 0)
                begin
                    e             = '{next_id, r.item, r.qty};
                    res.order_id  = next_id;
                    res.from_high = r.is_high;
                    next_id       = next_id + 1'b1;
                    res.status    = ST_FULL;
                    if (r.is_high && high_q.size() < HIGH_DEPTH)
                    begin
                        high_q.push_back(e);
                        res.status = ST_PLACED;
                    end
                    else if (!r.is_high && low_q.size() < LOW_DEPTH)
                    begin
                        low_q.push_back(e);
                        res.status = ST_PLACED;
                    end
                end
            KIND_SERVE:
            begin
                res.status = ST_SERVED;
                if (high_q.size() != 0)
                begin
                    e             = high_q.pop_front();
                    res.from_high = 1'b1;
                end
                else if (low_q.size() != 0)
                    e = low_q.pop_front();
                else
                    res.status = ST_EMPTY;
                if (res.status == ST_SERVED)
                begin
                    res.order_id = e.id;
                    res.item     = e.item;
                    res.qty      = e.qty;
                end
            end
            KIND_CANCEL:
            begin
                res.order_id = r.cancel_id;
                res.status   = ST_CANCELLED;
                pos          = find_id(high_q, r.cancel_id);
                if (pos >= 0)
                begin
                    high_q.delete(pos);
                    res.from_high = 1'b1;
                end
                else
                begin
                    pos = find_id(low_q, r.cancel_id);
                    if (pos >= 0)
                        low_q.delete(pos);
                    else
                        res.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(order_result_t got);
        order_result_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none actual status %0d id %0d",
                     $time, got.status, got.order_id);
            errors++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("order_id", want.order_id, got.order_id);
        compare_field("from_high_class", want.from_high, got.from_high);
        compare_field("served_item", want.item, got.item);
        compare_field("served_quantity", want.qty, got.qty);
    endfunction
endclass

module two_class_priority_order_queue_tb;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 2 * (HIGH_DEPTH + LOW_DEPTH) + 8;

    logic clk = 1'b0;
    logic rst_n;
    int   gap_pct;
    int   stall_pct;

    order_queue_mirror book;

    tcpoq_req_if req_ch();
    tcpoq_rsp_if rsp_ch();
    tcpoq_cfg_if cfg_ch();

    two_class_priority_order_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("two_class_priority_order_queue verification failed");
        $finish;
    end

    task automatic send_request(logic [KIND_W-1:0] kind, logic hi, logic [ITEM_W-1:0] item,
                                logic [QTY_W-1:0] qty, logic [ID_W-1:0] cid);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.is_high_class <= hi;
        req_ch.item_number   <= item;
        req_ch.quantity      <= qty;
        req_ch.cancel_id     <= cid;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request('{kind, hi, item, qty, cid});
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        book.write_register(index, data);
    endtask

    function automatic order_request_t random_request();
        order_request_t r;
        int             pick;
        r.kind      = KIND_UNUSED;
        r.is_high   = 1'($urandom_range(1));
        r.item      = 8'($urandom_range(255));
        r.qty       = 16'($urandom_range(65535));
        r.cancel_id = 16'($urandom_range(65535));
        pick        = $urandom_range(99);
        if (pick < 45)
        begin
            r.kind = KIND_PLACE;
            pick   = $urandom_range(99);
            if (pick < 80)
                r.item = 8'($urandom_range(int'(book.max_item), 1));
            else if (pick < 87)
                r.item = '0;
            else if (pick < 94 && book.max_item != 8'hFF)
                r.item = 8'($urandom_range(255, int'(book.max_item) + 1));
            pick = $urandom_range(99);
            if (pick < 85)
                r.qty = 16'($urandom_range(65535, 1));
            else if (pick < 92)
                r.qty = '0;
            else
                r.qty = $urandom_range(1) ? 16'hFFFF : 16'd1;
        end
        else if (pick < 72)
            r.kind = KIND_SERVE;
        else if (pick < 95)
        begin
            r.kind = KIND_CANCEL;
            if ($urandom_range(99) < 80)
                r.cancel_id = book.pick_live_id();
        end
        return r;
    endfunction

    initial
    begin
        order_result_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.status, rsp_ch.order_id, rsp_ch.from_high_class,
                        rsp_ch.served_item, rsp_ch.served_quantity};
                book.check_result(got);
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        order_request_t r;
        int             k;
        int             p;
        book                 = new();
        gap_pct              = 0;
        stall_pct            = 0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = '0;
        req_ch.is_high_class = 1'b0;
        req_ch.item_number   = '0;
        req_ch.quantity      = '0;
        req_ch.cancel_id     = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(KIND_SERVE, 1'b0, 8'd0, 16'd0, 16'd0);
        send_request(KIND_CANCEL, 1'b0, 8'd0, 16'd0, 16'd100);
        send_request(KIND_PLACE, 1'b0, 8'd0, 16'd5, 16'd0);
        send_request(KIND_PLACE, 1'b0, 8'd19, 16'd5, 16'd0);
        send_request(KIND_PLACE, 1'b1, 8'd18, 16'd0, 16'd0);
        send_request(KIND_UNUSED, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
        for (k = 0; k <= HIGH_DEPTH; k++)
            send_request(KIND_PLACE, 1'b1, 8'(18 - k), 16'(65535 - k), 16'd0);
        send_request(KIND_PLACE, 1'b0, 8'd1, 16'd1, 16'd0);
        send_request(KIND_PLACE, 1'b0, 8'd2, 16'd3, 16'd0);
        send_request(KIND_CANCEL, 1'b0, 8'd0, 16'd0, 16'd102);
        send_request(KIND_CANCEL, 1'b1, 8'd0, 16'd0, 16'd106);
        send_request(KIND_SERVE, 1'b0, 8'd0, 16'd0, 16'd0);
        send_request(KIND_SERVE, 1'b0, 8'd0, 16'd0, 16'd0);

        wait_drained();
        write_register(REG_ITEM_COUNT, 16'd255);
        write_register(REG_FIRST_ORDER_ID, 16'hFFFF);
        send_request(KIND_PLACE, 1'b0, 8'd255, 16'hFFFF, 16'd0);
        send_request(KIND_PLACE, 1'b1, 8'd1, 16'd2, 16'd0);

        // force a duplicate id in both queues to check high-first cancel
        wait_drained();
        write_register(REG_FIRST_ORDER_ID, 16'd103);
        send_request(KIND_PLACE, 1'b0, 8'd7, 16'd9, 16'd0);
        send_request(KIND_CANCEL, 1'b0, 8'd0, 16'd0, 16'd103);
        send_request(KIND_CANCEL, 1'b0, 8'd0, 16'd0, 16'd103);

        for (p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                    write_register(REG_FIRST_ORDER_ID, 16'd0);
                    write_register(REG_ITEM_COUNT, 16'd1);
                end
                1:
                begin
                    gap_pct   = 67;
                    stall_pct = 0;
                    write_register(REG_FIRST_ORDER_ID, 16'($urandom_range(65535)));
                    write_register(REG_ITEM_COUNT, 16'($urandom_range(255, 1)));
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 67;
                    write_register(REG_FIRST_ORDER_ID, 16'hFFF8);
                    write_register(REG_ITEM_COUNT, 16'd255);
                end
                default:
                begin
                    gap_pct   = 25;
                    stall_pct = 25;
                    write_register(REG_FIRST_ORDER_ID, 16'(FIRST_ID_RESET));
                    write_register(REG_ITEM_COUNT, 16'(ITEM_COUNT_RESET));
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    wait_drained();
                r = random_request();
                send_request(r.kind, r.is_high, r.item, r.qty, r.cancel_id);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("two_class_priority_order_queue verification clean");
        else
            $display("two_class_priority_order_queue verification failed");
        $finish;
    end
endmodule

FILE: files.f
src/tcpoq_pkg.sv
src/tcpoq_if.sv
src/tcpoq_ctrl.sv
src/tcpoq_dp.sv
src/two_class_priority_order_queue.sv
src/tcpoq_checker.sv
test/two_class_priority_order_queue_tb.sv
